[rtl/core/interval_range_allocator_macros.svh]
// Assertion macros for the interval range allocator.
`ifndef INTERVAL_RANGE_ALLOCATOR_MACROS_SVH
`define INTERVAL_RANGE_ALLOCATOR_MACROS_SVH

// Check that cond implies prop in the same cycle.
`define IRA_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("allocator check failed");

// Check that cond implies prop in the following cycle.
`define IRA_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("allocator check failed");

`endif

[rtl/core/ira_pkg.sv]
// Shared constants, types and cell controls of the interval range allocator.
`default_nettype none
package ira_pkg;
    localparam int NUM_RESOURCES = 16;
    localparam int MAX_RANGES    = 16;
    localparam int T_W           = 17;
    localparam int IDX_W         = $clog2(MAX_RANGES);
    localparam int CNT_W         = $clog2(MAX_RANGES + 1);
    localparam int ADDR_W        = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam logic [T_W-1:0] HORIZON = 17'd100000;

    localparam logic [2:0] ST_ASKED  = 3'd0;
    localparam logic [2:0] ST_LATER  = 3'd1;
    localparam logic [2:0] ST_NOFIT  = 3'd2;
    localparam logic [2:0] ST_NOROOM = 3'd3;
    localparam logic [2:0] ST_BAD    = 3'd4;

    typedef struct packed {
        logic [3:0]     resource_id;
        logic [T_W-1:0] want_start;
        logic [T_W-1:0] want_end;
    } req_t;

    typedef struct packed {
        logic [T_W-1:0] grant_start;
        logic [T_W-1:0] grant_end;
        logic [2:0]     status;
    } rsp_t;

    typedef struct packed {
        logic           vld;
        logic [T_W-1:0] beg;
        logic [T_W-1:0] fin;
    } entry_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_FIT,
        OP_REMOVE,
        OP_SETBEG,
        OP_SETFIN,
        OP_SPLIT,
        OP_WRITE
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [ADDR_W-1:0] addr;
        logic              fresh;
        logic [T_W-1:0]    ws;
        logic [T_W-1:0]    we;
        logic [T_W-1:0]    len;
        logic [T_W-1:0]    val;
        logic [T_W-1:0]    fin_k;
        logic [IDX_W-1:0]  k;
    } cell_ctrl_t;

    typedef struct packed {
        logic fa;
        logic fb;
    } cell_fit_t;
endpackage
`default_nettype wire

[rtl/core/ira_cell.sv]
// One slot of the free range chain: per-resource store, working copy and fit tests.
`default_nettype none
module ira_cell (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  ira_pkg::cell_ctrl_t         ctrl,
    input  wire [ira_pkg::IDX_W-1:0]    cell_idx,
    input  ira_pkg::entry_t             left_in,
    input  ira_pkg::entry_t             right_in,
    output ira_pkg::entry_t             cur,
    output ira_pkg::cell_fit_t          fit
);
    import ira_pkg::*;

    entry_t    mem [NUM_RESOURCES];
    entry_t    mem_q;
    entry_t    cur_reg;
    entry_t    cur_next;
    entry_t    init_ent;
    cell_fit_t fit_reg;
    cell_fit_t fit_next;
    logic [IDX_W:0] idx_x;
    logic [IDX_W:0] k_x;
    logic [IDX_W:0] k_plus;

    always_ff @(posedge aclk) begin
        if (ctrl.op == OP_WRITE) begin
            mem[ctrl.addr] <= cur_reg;
        end
        mem_q <= mem[ctrl.addr];
    end

    always_comb begin
        idx_x        = {1'b0, cell_idx};
        k_x          = {1'b0, ctrl.k};
        k_plus       = k_x + 1'b1;
        init_ent.vld = (cell_idx == '0);
        init_ent.beg = '0;
        init_ent.fin = (cell_idx == '0) ? HORIZON : '0;
        cur_next     = cur_reg;
        fit_next     = fit_reg;
        case (ctrl.op)
            OP_LOAD: begin
                cur_next = ctrl.fresh ? init_ent : mem_q;
            end
            OP_FIT: begin
                fit_next.fa = cur_reg.vld && (cur_reg.beg <= ctrl.ws) && (cur_reg.fin >= ctrl.we);
                fit_next.fb = cur_reg.vld && (cur_reg.fin >= ctrl.we)
                    && (cur_reg.fin >= cur_reg.beg)
                    && ((cur_reg.fin - cur_reg.beg) >= ctrl.len);
            end
            OP_REMOVE: begin
                if (idx_x >= k_x) begin
                    cur_next = right_in;
                end
            end
            OP_SETBEG: begin
                if (idx_x == k_x) begin
                    cur_next.beg = ctrl.val;
                end
            end
            OP_SETFIN: begin
                if (idx_x == k_x) begin
                    cur_next.fin = ctrl.val;
                end
            end
            OP_SPLIT: begin
                if (idx_x == k_x) begin
                    cur_next.fin = ctrl.ws;
                end else if (idx_x == k_plus) begin
                    cur_next.vld = 1'b1;
                    cur_next.beg = ctrl.we;
                    cur_next.fin = ctrl.fin_k;
                end else if (idx_x > k_plus) begin
                    cur_next = left_in;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (!aresetn) begin
            fit_reg <= '0;
        end else begin
            fit_reg <= fit_next;
        end
    end

    assign cur = cur_reg;
    assign fit = fit_reg;
endmodule
`default_nettype wire

[rtl/core/interval_range_allocator.sv]
// Top level of the interval range allocator: request sequencer over a chain of range cells.
//
//  channel | dir | word  | handshake
//  s_      | in  | req_t | s_valid / s_ready
//  m_      | out | rsp_t | m_valid / m_ready
//
// A request passes through read, load, fit, one scan step per free range of the
// resource (up to MAX_RANGES) plus one, decide, edit and write back. No fit and no
// room skip edit and write back. Bad requests are answered from idle, with the
// result valid in the cycle after they are taken.
// Reset clears the sequencer and the per-resource written flags; no clearing pass.
// One request is in flight at a time; s_ready stays low while a result waits.
`default_nettype none
module interval_range_allocator (
    input  wire           aclk,
    input  wire           aresetn,
    input  wire           s_valid,
    output logic          s_ready,
    input  ira_pkg::req_t s_word,
    output logic          m_valid,
    input  wire           m_ready,
    output ira_pkg::rsp_t m_word
);
    import ira_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_FIT,
        S_SCAN,
        S_DECIDE,
        S_EDIT,
        S_WRITE
    } state_t;

    state_t               state_reg;
    req_t                 req_reg;
    logic [CNT_W-1:0]     ptr_reg;
    logic [CNT_W-1:0]     n_reg;
    logic                 hit_a_reg;
    logic                 hit_b_reg;
    logic [IDX_W-1:0]     ka_reg;
    logic [IDX_W-1:0]     kb_reg;
    logic [T_W-1:0]       ab_reg;
    logic [T_W-1:0]       af_reg;
    logic [T_W-1:0]       bb_reg;
    logic [T_W-1:0]       bf_reg;
    cell_op_t             op_reg;
    logic [IDX_W-1:0]     k_reg;
    logic [T_W-1:0]       val_reg;
    rsp_t                 rsp_reg;
    logic [NUM_RESOURCES-1:0] touched_reg;
    logic                 m_valid_reg;
    rsp_t                 m_word_reg;

    cell_ctrl_t           ctrl;
    entry_t               cell_ent   [MAX_RANGES];
    cell_fit_t            cell_fit   [MAX_RANGES];
    entry_t               left_arr   [MAX_RANGES];
    entry_t               right_arr  [MAX_RANGES];
    logic [8:0]           rid_wide;
    logic [ADDR_W-1:0]    addr;
    logic [IDX_W-1:0]     ptr_idx;
    logic [T_W-1:0]       len;
    logic [T_W-1:0]       ge_b;
    logic                 bad;
    cell_op_t             dec_op;
    logic [IDX_W-1:0]     dec_k;
    logic [T_W-1:0]       dec_val;
    rsp_t                 dec_rsp;

    assign rid_wide = 9'(req_reg.resource_id);
    assign addr     = rid_wide[ADDR_W-1:0];
    assign ptr_idx  = ptr_reg[IDX_W-1:0];
    assign len      = req_reg.want_end - req_reg.want_start;
    assign ge_b     = bb_reg + len;
    assign bad      = (32'(s_word.resource_id) >= NUM_RESOURCES)
                   || (s_word.want_end <= s_word.want_start);

    always_comb begin
        ctrl.addr  = addr;
        ctrl.fresh = !touched_reg[addr];
        ctrl.ws    = req_reg.want_start;
        ctrl.we    = req_reg.want_end;
        ctrl.len   = len;
        ctrl.val   = val_reg;
        ctrl.fin_k = af_reg;
        ctrl.k     = k_reg;
        case (state_reg)
            S_LOAD:  ctrl.op = OP_LOAD;
            S_FIT:   ctrl.op = OP_FIT;
            S_EDIT:  ctrl.op = op_reg;
            S_WRITE: ctrl.op = OP_WRITE;
            default: ctrl.op = OP_NONE;
        endcase
    end

    always_comb begin
        for (int i = 0; i < MAX_RANGES; i++) begin
            left_arr[i]  = (i == 0) ? entry_t'('0) : cell_ent[(i == 0) ? 0 : i - 1];
            right_arr[i] = (i == MAX_RANGES - 1) ? entry_t'('0)
                         : cell_ent[(i == MAX_RANGES - 1) ? i : i + 1];
        end
    end

    for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
        ira_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .cell_idx (IDX_W'(g)),
            .left_in  (left_arr[g]),
            .right_in (right_arr[g]),
            .cur      (cell_ent[g]),
            .fit      (cell_fit[g])
        );
    end

    always_comb begin
        dec_op  = OP_NONE;
        dec_k   = ka_reg;
        dec_val = '0;
        dec_rsp = '{grant_start: '0, grant_end: '0, status: ST_NOFIT};
        if (hit_a_reg) begin
            dec_rsp = '{grant_start: req_reg.want_start, grant_end: req_reg.want_end,
                        status: ST_ASKED};
            if (req_reg.want_start == ab_reg && req_reg.want_end == af_reg) begin
                dec_op = OP_REMOVE;
            end else if (req_reg.want_start == ab_reg) begin
                dec_op  = OP_SETBEG;
                dec_val = req_reg.want_end;
            end else if (req_reg.want_end == af_reg) begin
                dec_op  = OP_SETFIN;
                dec_val = req_reg.want_start;
            end else if (n_reg >= CNT_W'(MAX_RANGES)) begin
                dec_rsp = '{grant_start: '0, grant_end: '0, status: ST_NOROOM};
            end else begin
                dec_op = OP_SPLIT;
            end
        end else if (hit_b_reg) begin
            dec_k   = kb_reg;
            dec_rsp = '{grant_start: bb_reg, grant_end: ge_b, status: ST_LATER};
            if ((bf_reg - bb_reg) == len) begin
                dec_op = OP_REMOVE;
            end else begin
                dec_op  = OP_SETBEG;
                dec_val = ge_b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            touched_reg <= '0;
            m_valid_reg <= 1'b0;
            hit_a_reg   <= 1'b0;
            hit_b_reg   <= 1'b0;
            ptr_reg     <= '0;
            n_reg       <= '0;
            op_reg      <= OP_NONE;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        req_reg   <= s_word;
                        hit_a_reg <= 1'b0;
                        hit_b_reg <= 1'b0;
                        ptr_reg   <= '0;
                        if (bad) begin
                            m_word_reg  <= '{grant_start: '0, grant_end: '0, status: ST_BAD};
                            m_valid_reg <= 1'b1;
                        end else begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:  state_reg <= S_LOAD;
                S_LOAD:  state_reg <= S_FIT;
                S_FIT:   state_reg <= S_SCAN;
                S_SCAN: begin
                    if (ptr_reg == CNT_W'(MAX_RANGES) || !cell_ent[ptr_idx].vld) begin
                        n_reg     <= ptr_reg;
                        state_reg <= S_DECIDE;
                    end else begin
                        if (cell_fit[ptr_idx].fa && !hit_a_reg) begin
                            hit_a_reg <= 1'b1;
                            ka_reg    <= ptr_idx;
                            ab_reg    <= cell_ent[ptr_idx].beg;
                            af_reg    <= cell_ent[ptr_idx].fin;
                        end
                        if (cell_fit[ptr_idx].fb && !hit_b_reg) begin
                            hit_b_reg <= 1'b1;
                            kb_reg    <= ptr_idx;
                            bb_reg    <= cell_ent[ptr_idx].beg;
                            bf_reg    <= cell_ent[ptr_idx].fin;
                        end
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                S_DECIDE: begin
                    op_reg  <= dec_op;
                    k_reg   <= dec_k;
                    val_reg <= dec_val;
                    rsp_reg <= dec_rsp;
                    if (dec_op == OP_NONE) begin
                        m_word_reg  <= dec_rsp;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end else begin
                        state_reg <= S_EDIT;
                    end
                end
                S_EDIT:  state_reg <= S_WRITE;
                S_WRITE: begin
                    touched_reg[addr] <= 1'b1;
                    m_word_reg        <= rsp_reg;
                    m_valid_reg       <= 1'b1;
                    state_reg         <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

`include "interval_range_allocator_macros.svh"

    `IRA_ASSERT_IMP(a_zero_unless_granted, m_valid && m_word.status != ST_ASKED && m_word.status != ST_LATER, m_word.grant_start == '0 && m_word.grant_end == '0)
    `IRA_ASSERT_IMP(a_asked_nonempty, m_valid && m_word.status == ST_ASKED, m_word.grant_end > m_word.grant_start)
    `IRA_ASSERT_NXT(a_one_in_flight, s_valid && s_ready, !s_ready)
    `IRA_ASSERT_IMP(a_scan_bound, state_reg == S_SCAN, ptr_reg <= CNT_W'(MAX_RANGES))
endmodule
`default_nettype wire
